/* rtl/serial_time_and_light_command_parser_core_assert.svh */
// Assertion macros shared by the parser modules.
`ifndef SERIAL_TIME_AND_LIGHT_COMMAND_PARSER_CORE_ASSERT_SVH
`define SERIAL_TIME_AND_LIGHT_COMMAND_PARSER_CORE_ASSERT_SVH

// Condition implies a consequence in the same cycle.
`define SCP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies a consequence in the next cycle.
`define SCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/scp_pkg.sv */
// Types, character codes and status codes of the time and light command parser.
package scp_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [7:0] CHAR_R     = 8'h52;
   localparam logic [7:0] CHAR_Y     = 8'h59;
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_X     = 8'h58;

   localparam int TIME_DIGITS = 6;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [6:0]  MAX_HOUR      = 7'd23;
   localparam logic [6:0]  MAX_MIN_SEC   = 7'd59;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [16:0] SECS_PER_MIN  = 17'd60;

   // Time command error codes.
   localparam logic [1:0] TERR_NONE     = 2'd0;
   localparam logic [1:0] TERR_LENGTH   = 2'd1;
   localparam logic [1:0] TERR_MINUS    = 2'd2;
   localparam logic [1:0] TERR_NONDIGIT = 2'd3;

   // Light command error codes.
   localparam logic [2:0] LERR_NONE      = 3'd0;
   localparam logic [2:0] LERR_DIGIT     = 3'd1;
   localparam logic [2:0] LERR_LOWER     = 3'd2;
   localparam logic [2:0] LERR_NONLETTER = 3'd3;
   localparam logic [2:0] LERR_BADLETTER = 3'd4;
   localparam logic [2:0] LERR_EMPTY     = 3'd5;

   // Result status codes.
   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_LENGTH     = 4'd1;
   localparam logic [3:0] ST_MINUS      = 4'd2;
   localparam logic [3:0] ST_NONDIGIT   = 4'd3;
   localparam logic [3:0] ST_RANGE      = 4'd4;
   localparam logic [3:0] ST_ZERO       = 4'd5;
   localparam logic [3:0] ST_EMPTY      = 4'd6;
   localparam logic [3:0] ST_DIGIT      = 4'd7;
   localparam logic [3:0] ST_LOWER      = 4'd8;
   localparam logic [3:0] ST_NONLETTER  = 4'd9;
   localparam logic [3:0] ST_BADLETTER  = 4'd10;

   // Everything the back end needs to finish one framed command.
   typedef struct packed {
      logic       is_time;
      logic [1:0] time_err;
      logic [6:0] hours;
      logic [6:0] minutes;
      logic [6:0] seconds;
      logic [2:0] light_err;
   } frame_type;

   // First light error that one byte raises, if any.
   function automatic logic [2:0] light_code(input logic [7:0] b);
      logic [2:0] code;
      if (b inside {[CHAR_ZERO:CHAR_NINE]}) begin
         code = LERR_DIGIT;
      end else if (b inside {[CHAR_LO_A:CHAR_LO_Z]}) begin
         code = LERR_LOWER;
      end else if (!(b inside {[CHAR_UP_A:CHAR_UP_Z]})) begin
         code = LERR_NONLETTER;
      end else if (!(b inside {CHAR_R, CHAR_Y, CHAR_G})) begin
         code = LERR_BADLETTER;
      end else begin
         code = LERR_NONE;
      end
      return code;
   endfunction

endpackage

/* rtl/scp_front.sv */
// Front end: takes bytes, runs the per-byte checks and frames commands on 'X'.
module scp_front #(
   parameter int MAX_CHARS = 127
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   output logic                out_push,
   output scp_pkg::frame_type  out_frame
);
   import scp_pkg::*;

   localparam int CountW = $clog2(MAX_CHARS + 1);

   logic [CountW-1:0] count_ff, count_in;
   logic              ended_ff, ended_in;
   logic              first_zero_ff, first_zero_in;
   logic [1:0]        terr_ff, terr_in;
   logic [6:0]        hours_ff, hours_in;
   logic [6:0]        minutes_ff, minutes_in;
   logic [6:0]        seconds_ff, seconds_in;
   logic [2:0]        lerr_ff, lerr_in;
   logic [6:0]        digit;

   assign digit = 7'(in_byte - CHAR_ZERO);

   always_comb begin
      count_in      = count_ff;
      ended_in      = ended_ff;
      first_zero_in = first_zero_ff;
      terr_in       = terr_ff;
      hours_in      = hours_ff;
      minutes_in    = minutes_ff;
      seconds_in    = seconds_ff;
      lerr_in       = lerr_ff;
      out_push      = 1'b0;

      out_frame.is_time   = first_zero_ff;
      out_frame.time_err  = (!ended_ff && count_ff != CountW'(TIME_DIGITS)) ?
                            TERR_LENGTH : terr_ff;
      out_frame.hours     = hours_ff;
      out_frame.minutes   = minutes_ff;
      out_frame.seconds   = seconds_ff;
      out_frame.light_err = lerr_ff;

      if (in_valid) begin
         if (in_byte == CHAR_X) begin
            if (count_ff != '0) begin
               out_push      = 1'b1;
               count_in      = '0;
               ended_in      = 1'b0;
               first_zero_in = 1'b0;
               terr_in       = TERR_NONE;
               hours_in      = '0;
               minutes_in    = '0;
               seconds_in    = '0;
               lerr_in       = LERR_NONE;
            end
         end else if (count_ff < CountW'(MAX_CHARS)) begin
            count_in = count_ff + 1'b1;
            if (!ended_ff) begin
               if (in_byte == CHAR_NUL) begin
                  // A zero byte closes the text; later bytes only count.
                  ended_in = 1'b1;
                  if (count_ff != CountW'(TIME_DIGITS)) terr_in = TERR_LENGTH;
                  if (count_ff == '0) lerr_in = LERR_EMPTY;
               end else begin
                  if (count_ff == '0 && in_byte == CHAR_ZERO) first_zero_in = 1'b1;
                  if (lerr_ff == LERR_NONE) lerr_in = light_code(in_byte);
                  if (count_ff >= CountW'(TIME_DIGITS)) begin
                     terr_in = TERR_LENGTH;
                  end else if (terr_ff == TERR_NONE) begin
                     if (in_byte == CHAR_MINUS) begin
                        terr_in = TERR_MINUS;
                     end else if (!(in_byte inside {[CHAR_ZERO:CHAR_NINE]})) begin
                        terr_in = TERR_NONDIGIT;
                     end else if (count_ff < CountW'(2)) begin
                        hours_in = 7'(hours_ff * 7'd10 + digit);
                     end else if (count_ff < CountW'(4)) begin
                        minutes_in = 7'(minutes_ff * 7'd10 + digit);
                     end else begin
                        seconds_in = 7'(seconds_ff * 7'd10 + digit);
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ended_ff      <= 1'b0;
         first_zero_ff <= 1'b0;
         terr_ff       <= TERR_NONE;
         hours_ff      <= '0;
         minutes_ff    <= '0;
         seconds_ff    <= '0;
         lerr_ff       <= LERR_NONE;
      end else begin
         count_ff      <= count_in;
         ended_ff      <= ended_in;
         first_zero_ff <= first_zero_in;
         terr_ff       <= terr_in;
         hours_ff      <= hours_in;
         minutes_ff    <= minutes_in;
         seconds_ff    <= seconds_in;
         lerr_ff       <= lerr_in;
      end
   end

endmodule

/* rtl/scp_queue.sv */
// Short queue of framed commands between the front end and the back end.
`include "serial_time_and_light_command_parser_core_assert.svh"

module scp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  scp_pkg::frame_type  push_frame,
   output logic                full,
   input  logic                pop,
   output scp_pkg::frame_type  head_frame,
   output logic                empty
);
   import scp_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   frame_type        slots_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CntW'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);
   assign head_frame = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_frame;
      end
   end

   `SCP_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CntW'(QUEUE_DEPTH), "queue count overflow")
   `SCP_ASSERT_SAME(a_push_not_full, push, !full, "frame pushed into a full queue")
   `SCP_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "lost push")

endmodule

/* rtl/scp_back.sv */
// Back end: range check, seconds total and status of one framed command.
`include "serial_time_and_light_command_parser_core_assert.svh"

module scp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  scp_pkg::frame_type  q_frame,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic                rsp_is_time,
   output logic [3:0]          rsp_status,
   output logic [16:0]         rsp_total_seconds
);
   import scp_pkg::*;

   logic        valid_ff, valid_in;
   logic        is_time_ff;
   logic [3:0]  status_ff, status_in;
   logic [16:0] total_ff, total_in;
   logic [16:0] secs;
   logic        out_of_range;
   logic        time_kind_ok;
   logic        light_kind_ok;
   logic        time_ok_held;

   // The output register frees up when it is empty or being read this cycle.
   assign q_pop    = !q_empty && (!valid_ff || rsp_pop);
   assign valid_in = q_pop || (valid_ff && !rsp_pop);

   assign out_of_range = (q_frame.hours > MAX_HOUR) || (q_frame.minutes > MAX_MIN_SEC) ||
                         (q_frame.seconds > MAX_MIN_SEC);
   assign secs = 17'(17'(q_frame.hours) * SECS_PER_HOUR) +
                 17'(17'(q_frame.minutes) * SECS_PER_MIN) + 17'(q_frame.seconds);

   always_comb begin
      status_in = ST_OK;
      total_in  = '0;
      if (q_frame.is_time) begin
         case (q_frame.time_err)
            TERR_LENGTH:   status_in = ST_LENGTH;
            TERR_MINUS:    status_in = ST_MINUS;
            TERR_NONDIGIT: status_in = ST_NONDIGIT;
            default: begin
               if (out_of_range) begin
                  status_in = ST_RANGE;
               end else if (secs == '0) begin
                  status_in = ST_ZERO;
               end else begin
                  total_in = secs;
               end
            end
         endcase
      end else begin
         case (q_frame.light_err)
            LERR_DIGIT:     status_in = ST_DIGIT;
            LERR_LOWER:     status_in = ST_LOWER;
            LERR_NONLETTER: status_in = ST_NONLETTER;
            LERR_BADLETTER: status_in = ST_BADLETTER;
            LERR_EMPTY:     status_in = ST_EMPTY;
            default:        status_in = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         is_time_ff <= q_frame.is_time;
         status_ff  <= status_in;
         total_ff   <= total_in;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_is_time       = is_time_ff;
   assign rsp_status        = status_ff;
   assign rsp_total_seconds = total_ff;

   assign time_kind_ok  = is_time_ff && (status_ff <= ST_ZERO);
   assign light_kind_ok = !is_time_ff &&
                          (status_ff == ST_OK || status_ff inside {[ST_EMPTY:ST_BADLETTER]});
   assign time_ok_held  = valid_ff && is_time_ff && (status_ff == ST_OK);

   `SCP_ASSERT_SAME(a_light_no_secs, valid_ff && !is_time_ff, total_ff == '0, "light with secs")
   `SCP_ASSERT_SAME(a_time_ok_secs, time_ok_held, total_ff != '0, "good time without seconds")
   `SCP_ASSERT_SAME(a_status_kind, valid_ff, time_kind_ok || light_kind_ok, "status off kind")

endmodule

/* rtl/serial_time_and_light_command_parser_core.sv */
// Top level of the serial time and light command parser.
//
//   Channel   Direction  Handshake          Beat contents
//   req_      in         req_push/req_full  req_data_byte (one received byte)
//   rsp_      out        rsp_pop/rsp_empty  rsp_is_time, rsp_status, rsp_total_seconds
//
// The block takes one byte per cycle while the frame queue is not full. The
// frame of a command is written into the frame queue at the edge that accepts
// its framing 'X' beat. It moves into the back-end output register once that
// register is free and nothing waits ahead of it, and shows on the rsp_ ports.
// Reset is synchronous and clears the byte checks, the queue and the output.
// When the reader stops popping, the output register holds its beat and up to
// four framed commands wait in the queue; only then does req_full rise.
module serial_time_and_light_command_parser_core #(
   parameter int MAX_CHARS = 127
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_is_time,
   output logic [3:0]  rsp_status,
   output logic [16:0] rsp_total_seconds
);
   import scp_pkg::*;

   logic      req_accept;
   logic      frame_push;
   frame_type frame_in;
   frame_type frame_head;
   logic      queue_full;
   logic      queue_empty;
   logic      queue_pop;

   // Input stalls only when the frame queue is full. This is conservative:
   // only an 'X' beat pushes, but it keeps the accept path a single gate.
   assign req_full   = queue_full;
   assign req_accept = req_push && !queue_full;

   // The front end keeps the running time and light checks for the command
   // being received and emits one frame for each 'X' that ends stored text.
   scp_front #(
      .MAX_CHARS (MAX_CHARS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_byte   (req_data_byte),
      .out_push  (frame_push),
      .out_frame (frame_in)
   );

   // The queue decouples byte intake from result delivery.
   scp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (frame_push),
      .push_frame (frame_in),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_frame (frame_head),
      .empty      (queue_empty)
   );

   // The back end finishes each frame: range check, seconds total and the
   // final status code, registered for the reader.
   scp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (queue_empty),
      .q_frame           (frame_head),
      .q_pop             (queue_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_is_time       (rsp_is_time),
      .rsp_status        (rsp_status),
      .rsp_total_seconds (rsp_total_seconds)
   );

endmodule

/* tb/tb_serial_time_and_light_command_parser_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the serial time and light command parser core.
module tb_serial_time_and_light_command_parser_core;
   import scp_pkg::*;

   localparam int MAX_CHARS   = 127;
   localparam int ITEM_TARGET = 1450;
   localparam int CYCLE_LIMIT = 400000;
   // Drain time after the last expected beat.
   localparam int DRAIN_CYCLES = 8;

   // One beat of the result channel.
   typedef struct packed {
      logic        is_time;
      logic [3:0]  status;
      logic [16:0] seconds;
   } cmd_result_type;

   // One row of the directed table. A typed row carries its own expected beat.
   typedef struct packed {
      logic [7:0]     data;
      logic           typed;
      cmd_result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_data_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic        rsp_is_time;
   logic [3:0]  rsp_status;
   logic [16:0] rsp_total_seconds;

   serial_time_and_light_command_parser_core #(
      .MAX_CHARS(MAX_CHARS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_data_byte    (req_data_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_is_time      (rsp_is_time),
      .rsp_status       (rsp_status),
      .rsp_total_seconds(rsp_total_seconds)
   );

   // Parser state as the predictor sees it, at the widths the block uses.
   logic [6:0] stored_len;
   logic       text_closed;
   logic       leads_with_zero;
   logic [1:0] time_fault;
   logic [6:0] hours_acc;
   logic [6:0] minutes_acc;
   logic [6:0] seconds_acc;
   logic [2:0] light_fault;

   cmd_result_type pending_results[$];
   stim_row_type   directed_rows[$];
   int             errors;
   int             items_sent;
   int             cycles;
   // While set, neither side inserts idle cycles.
   bit             calm;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic clear_parser();
      stored_len      = '0;
      text_closed     = 1'b0;
      leads_with_zero = 1'b0;
      time_fault      = TERR_NONE;
      hours_acc       = '0;
      minutes_acc     = '0;
      seconds_acc     = '0;
      light_fault     = LERR_NONE;
   endtask

   // Advances the parser by one accepted byte. A framing 'X' with text stored
   // returns the command's result and clears the state again.
   task automatic parse_byte(input logic [7:0] b, output logic framed,
                             output cmd_result_type res);
      logic [6:0]  pos;
      logic [7:0]  digit;
      logic [3:0]  st;
      logic [16:0] secs;
      framed = 1'b0;
      res    = '0;
      secs   = '0;
      st     = ST_OK;
      digit  = b - CHAR_ZERO;
      if (b != CHAR_X) begin
         // Bytes past the storage limit vanish without touching anything.
         if (stored_len < MAX_CHARS) begin
            pos        = stored_len;
            stored_len = pos + 7'd1;
            if (!text_closed) begin
               if (b == CHAR_NUL) begin
                  // A zero byte closes the text. It forces a length error
                  // unless it lands right after six characters.
                  text_closed = 1'b1;
                  if (pos != TIME_DIGITS) time_fault = TERR_LENGTH;
                  if (pos == 0) light_fault = LERR_EMPTY;
               end else begin
                  if (pos == 0 && b == CHAR_ZERO) leads_with_zero = 1'b1;
                  // Only the first light error is kept.
                  if (light_fault == LERR_NONE) begin
                     if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                        light_fault = LERR_DIGIT;
                     end else if (b >= CHAR_LO_A && b <= CHAR_LO_Z) begin
                        light_fault = LERR_LOWER;
                     end else if (b < CHAR_UP_A || b > CHAR_UP_Z) begin
                        light_fault = LERR_NONLETTER;
                     end else if (b != CHAR_R && b != CHAR_Y && b != CHAR_G) begin
                        light_fault = LERR_BADLETTER;
                     end
                  end
                  // A seventh character overrides any earlier time error.
                  if (pos >= TIME_DIGITS) begin
                     time_fault = TERR_LENGTH;
                  end else if (time_fault == TERR_NONE) begin
                     if (b == CHAR_MINUS) begin
                        time_fault = TERR_MINUS;
                     end else if (b < CHAR_ZERO || b > CHAR_NINE) begin
                        time_fault = TERR_NONDIGIT;
                     end else if (pos < 2) begin
                        hours_acc = hours_acc * 7'd10 + digit[6:0];
                     end else if (pos < 4) begin
                        minutes_acc = minutes_acc * 7'd10 + digit[6:0];
                     end else begin
                        seconds_acc = seconds_acc * 7'd10 + digit[6:0];
                     end
                  end
               end
            end
         end
      end else if (stored_len != 0) begin
         // A text not closed by a zero byte must be exactly six characters.
         if (!text_closed && stored_len != TIME_DIGITS) time_fault = TERR_LENGTH;
         if (leads_with_zero) begin
            case (time_fault)
               TERR_LENGTH:   st = ST_LENGTH;
               TERR_MINUS:    st = ST_MINUS;
               TERR_NONDIGIT: st = ST_NONDIGIT;
               default: begin
                  if (hours_acc > MAX_HOUR || minutes_acc > MAX_MIN_SEC ||
                      seconds_acc > MAX_MIN_SEC) begin
                     st = ST_RANGE;
                  end else begin
                     secs = hours_acc * SECS_PER_HOUR + minutes_acc * SECS_PER_MIN +
                            seconds_acc;
                     st   = (secs == 0) ? ST_ZERO : ST_OK;
                  end
               end
            endcase
         end else begin
            case (light_fault)
               LERR_DIGIT:     st = ST_DIGIT;
               LERR_LOWER:     st = ST_LOWER;
               LERR_NONLETTER: st = ST_NONLETTER;
               LERR_BADLETTER: st = ST_BADLETTER;
               LERR_EMPTY:     st = ST_EMPTY;
               default:        st = ST_OK;
            endcase
         end
         res.is_time = leads_with_zero;
         res.status  = st;
         res.seconds = secs;
         framed      = 1'b1;
         clear_parser();
      end
   endtask

   // Idle length before a beat: mostly none, sometimes a few, rarely many.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Offers one byte on the request side and predicts it once it is taken.
   task automatic send_byte(input stim_row_type row);
      int             gap;
      logic           framed;
      logic           ignored;
      cmd_result_type res;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push      <= 1'b1;
      req_data_byte <= row.data;
      @(posedge clock);
      while (req_full) @(posedge clock);
      // Dropped bytes and empty frames do not count toward the item budget.
      ignored = (row.data == CHAR_X) ? (stored_len == 0) : (stored_len >= MAX_CHARS);
      if (!ignored) items_sent++;
      parse_byte(row.data, framed, res);
      if (row.typed) pending_results.push_back(row.want);
      else if (framed) pending_results.push_back(res);
   endtask

   task automatic add_byte(input logic [7:0] b);
      directed_rows.push_back('{data: b, typed: 1'b0, want: '0});
   endtask

   task automatic add_text(input string s);
      foreach (s[i]) add_byte(s[i]);
   endtask

   task automatic add_frame(input logic is_time, input logic [3:0] status,
                            input logic [16:0] seconds);
      directed_rows.push_back('{data: CHAR_X, typed: 1'b1,
                                want: '{is_time: is_time, status: status, seconds: seconds}});
   endtask

   task automatic check_field(input string field, input logic [16:0] want,
                              input logic [16:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Result side: random stalls on pop. It starts once reset is released.
   initial begin
      int gap;
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = pick_gap();
         repeat (gap) begin
            @(negedge clock);
            rsp_pop <= 1'b0;
         end
         @(negedge clock);
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   // Every popped beat is matched against the oldest expected command result.
   always @(posedge clock) begin
      cmd_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                     $time, rsp_is_time, rsp_status, rsp_total_seconds);
         end else begin
            want = pending_results.pop_front();
            check_field("is_time", 17'(want.is_time), 17'(rsp_is_time));
            check_field("status", 17'(want.status), 17'(rsp_status));
            check_field("total_seconds", want.seconds, rsp_total_seconds);
         end
      end
   end

   initial begin
      logic [7:0] cmd[$];
      int         kind;
      int         len;
      int         pos;
      logic [7:0] corrupt;

      reset         = 1'b1;
      req_push      = 1'b0;
      req_data_byte = '0;
      errors        = 0;
      items_sent    = 0;
      cycles        = 0;
      calm          = 1'b0;
      clear_parser();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. A lone 'X' frames nothing and must give no beat.
      add_byte(CHAR_X);
      // Largest time the format can hold, since the hour starts with a zero.
      add_text("095959");
      add_frame(1'b1, ST_OK, 17'd35999);
      // All-zero time is well formed but rejected.
      add_text("000000");
      add_frame(1'b1, ST_ZERO, '0);
      // A minus wins over the later digits when the length is right.
      add_text("0-1234");
      add_frame(1'b1, ST_MINUS, '0);
      // A zero byte first makes an empty light command.
      add_byte(CHAR_NUL);
      add_frame(1'b0, ST_EMPTY, '0);
      // Bytes after a zero byte are stored but no longer part of the text.
      add_text("R");
      add_byte(CHAR_NUL);
      add_text("q");
      add_frame(1'b0, ST_OK, '0);
      // The top byte value is a non-letter.
      add_byte(8'hFF);
      add_frame(1'b0, ST_NONLETTER, '0);
      foreach (directed_rows[i]) send_byte(directed_rows[i]);

      // Random part. Most commands are well-formed time or light texts with
      // random content; the rest are corrupted, mis-sized, overlong or noise.
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 7) == 0) calm = !calm;
         cmd.delete();
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            cmd.push_back(CHAR_ZERO);
            if ($urandom_range(0, 19) == 0) begin
               repeat (5) cmd.push_back(CHAR_ZERO);
            end else begin
               // Tens of minutes and seconds run past five now and then.
               for (pos = 1; pos < TIME_DIGITS; pos++) begin
                  if ((pos == 2 || pos == 4) && $urandom_range(0, 4) != 0)
                     cmd.push_back(CHAR_ZERO + 8'($urandom_range(0, 5)));
                  else
                     cmd.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
               end
            end
         end else if (kind < 70) begin
            len = $urandom_range(1, 8);
            repeat (len) begin
               case ($urandom_range(0, 2))
                  0:       cmd.push_back(CHAR_R);
                  1:       cmd.push_back(CHAR_Y);
                  default: cmd.push_back(CHAR_G);
               endcase
            end
         end else if (kind < 75) begin
            // Nothing stored: the framing byte alone.
         end else if (kind < 77) begin
            // Runs past the storage limit so the tail is dropped.
            len = $urandom_range(MAX_CHARS + 1, MAX_CHARS + 20);
            if ($urandom_range(0, 1) == 0) begin
               cmd.push_back(CHAR_ZERO);
               repeat (len - 1) cmd.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            end else begin
               repeat (len) cmd.push_back($urandom_range(0, 1) ? CHAR_R : CHAR_G);
            end
         end else if (kind < 85) begin
            // Time with the wrong number of digits.
            len = $urandom_range(0, 9);
            if (len == TIME_DIGITS - 1) len = TIME_DIGITS + 1;
            cmd.push_back(CHAR_ZERO);
            repeat (len) cmd.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
         end else begin
            len = $urandom_range(1, 6);
            repeat (len) cmd.push_back(8'($urandom_range(0, 255)));
         end

         // Damage one byte of a well-formed text now and then.
         if (kind < 70 && $urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
               0:       corrupt = 8'($urandom_range(0, 255));
               1:       corrupt = CHAR_MINUS;
               2:       corrupt = CHAR_NUL;
               3:       corrupt = CHAR_LO_A + 8'($urandom_range(0, 25));
               4:       corrupt = CHAR_UP_A + 8'($urandom_range(0, 25));
               default: corrupt = CHAR_ZERO + 8'($urandom_range(0, 9));
            endcase
            cmd[$urandom_range(0, cmd.size() - 1)] = corrupt;
         end
         // Close some texts with a zero byte followed by junk.
         if (kind < 85 && $urandom_range(0, 11) == 0) begin
            cmd.push_back(CHAR_NUL);
            repeat ($urandom_range(0, 3)) cmd.push_back(8'($urandom_range(0, 255)));
         end
         // Noise is left unframed half of the time and runs into the next command.
         if (kind < 85 || $urandom_range(0, 1) == 0) cmd.push_back(CHAR_X);

         foreach (cmd[i]) send_byte('{data: cmd[i], typed: 1'b0, want: '0});
      end

      @(negedge clock);
      req_push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
